@@ src/tip_pkg.sv @@
// Shared types and constants for the text integer parser.
package tip_pkg;

    // Default for the saturation length of the character position.
    localparam int MAX_LENGTH_DEF = 4096;

    // Largest position that the 13-bit count fields can hold.
    localparam int POS_LIMIT = 8191;
    localparam int POS_W     = 13;
    localparam int VALUE_W   = 64;

    // Number bases that the prefix letters select.
    localparam logic [4:0] BASE_BIN = 5'd2;
    localparam logic [4:0] BASE_OCT = 5'd8;
    localparam logic [4:0] BASE_DEC = 5'd10;
    localparam logic [4:0] BASE_HEX = 5'd16;

    // Classified character word handed from the front to the back.
    typedef struct packed {
        logic       end_flag;
        logic       escape;
        logic       blank;
        logic       minus;
        logic       plus;
        logic       zero_char;
        logic       letter_hit;
        logic [4:0] letter_base;
        logic       hex_hit;
        logic [3:0] hex_val;
    } tip_cls_t;

endpackage

@@ src/tip_if.sv @@
// Stream channels for character words and result words.
interface tip_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_string;
    logic       escape_mode;

    modport source (output valid, char_code, end_of_string, escape_mode, input ready);
    modport sink (input valid, char_code, end_of_string, escape_mode, output ready);
endinterface

interface tip_out_if;
    logic               valid;
    logic               ready;
    logic               ok;
    logic signed [63:0] result_value;
    logic [12:0]        consumed_count;

    modport source (output valid, ok, result_value, consumed_count, input ready);
    modport sink (input valid, ok, result_value, consumed_count, output ready);
endinterface

@@ src/tip_front.sv @@
// Front end: accepts character words and classifies each byte.
module tip_front (
    tip_in_if.sink           char_in,
    input  logic             q_ready,
    output logic             push,
    output tip_pkg::tip_cls_t push_word
);
    import tip_pkg::*;

    logic [7:0] c;
    logic [7:0] low;

    assign c = char_in.char_code;

    // Fold upper-case letters to lower case for the prefix letter check.
    assign low = (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;

    assign char_in.ready = q_ready;
    assign push          = char_in.valid && q_ready;

    // Character classes used by the parser.
    always_comb
    begin
        push_word             = '0;
        push_word.end_flag    = char_in.end_of_string;
        push_word.escape      = char_in.escape_mode;
        push_word.blank       = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
        push_word.minus       = (c == 8'h2D);
        push_word.plus        = (c == 8'h2B);
        push_word.zero_char   = (c == 8'h30);
        case (low)
            8'h62:   begin push_word.letter_hit = 1'b1; push_word.letter_base = BASE_BIN; end
            8'h6F:   begin push_word.letter_hit = 1'b1; push_word.letter_base = BASE_OCT; end
            8'h64:   begin push_word.letter_hit = 1'b1; push_word.letter_base = BASE_DEC; end
            8'h78:   begin push_word.letter_hit = 1'b1; push_word.letter_base = BASE_HEX; end
            default: begin push_word.letter_hit = 1'b0; push_word.letter_base = BASE_DEC; end
        endcase
        if (c >= 8'h30 && c <= 8'h39)
        begin
            push_word.hex_hit = 1'b1;
            push_word.hex_val = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            push_word.hex_hit = 1'b1;
            push_word.hex_val = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            push_word.hex_hit = 1'b1;
            push_word.hex_val = 4'(c - 8'h37);
        end
    end
endmodule

@@ src/tip_queue.sv @@
// Two-entry queue that decouples the front end from the parser.
module tip_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tip_pkg::tip_cls_t push_word,
    output logic              q_ready,
    input  logic              pop,
    output logic              q_valid,
    output tip_pkg::tip_cls_t q_word
);
    import tip_pkg::*;

    tip_cls_t   mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign q_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_word  = mem[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end
endmodule

@@ src/tip_back.sv @@
// Back end: parser state machine, accumulator and result register.
module tip_back #(
    parameter int MAX_LENGTH = tip_pkg::MAX_LENGTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  tip_pkg::tip_cls_t q_word,
    output logic              pop,
    tip_out_if.source         result_out
);
    import tip_pkg::*;

    localparam int POS_CAP_I = (MAX_LENGTH < POS_LIMIT) ? MAX_LENGTH : POS_LIMIT;
    localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_CAP_I);

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_LEAD  = 3'd1;
    localparam logic [2:0] PH_GAP   = 3'd2;
    localparam logic [2:0] PH_ZERO  = 3'd3;
    localparam logic [2:0] PH_BASE  = 3'd4;
    localparam logic [2:0] PH_DIGIT = 3'd5;
    localparam logic [2:0] PH_DONE  = 3'd6;

    logic [2:0]         phase_reg, phase_next;
    logic               mode_reg, mode_next;
    logic               minus_reg, minus_next;
    logic [4:0]         base_reg, base_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               seen_reg, seen_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   stop_reg, stop_next;

    logic               out_valid_reg, out_valid_next;
    logic               ok_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [POS_W-1:0]   count_reg;

    logic [VALUE_W-1:0] scaled;
    logic [VALUE_W-1:0] acc_cand;
    logic               digit_ok;
    logic               finish;

    // Take a word whenever the result register can hold a new result.
    assign pop = q_valid && (!out_valid_reg || result_out.ready);

    // Multiply by the base as shifts and one shift-add.
    always_comb
    begin
        case (base_reg)
            BASE_BIN: scaled = acc_reg << 1;
            BASE_OCT: scaled = acc_reg << 3;
            BASE_HEX: scaled = acc_reg << 4;
            default:  scaled = (acc_reg << 3) + (acc_reg << 1);
        endcase
        acc_cand = scaled + VALUE_W'(q_word.hex_val);
        digit_ok = q_word.hex_hit && ({1'b0, q_word.hex_val} < base_reg);
    end

    // Parser step; one word may pass through several phases in a cycle.
    always_comb
    begin
        phase_next = phase_reg;
        mode_next  = mode_reg;
        minus_next = minus_reg;
        base_next  = base_reg;
        acc_next   = acc_reg;
        seen_next  = seen_reg;
        pos_next   = pos_reg;
        stop_next  = stop_reg;
        finish     = 1'b0;
        if (pop)
        begin
            if (q_word.end_flag)
            begin
                phase_next = PH_START;
                mode_next  = 1'b0;
                minus_next = 1'b0;
                base_next  = BASE_DEC;
                acc_next   = '0;
                seen_next  = 1'b0;
                pos_next   = '0;
                stop_next  = '0;
            end
            else
            begin
                if (phase_reg == PH_START)
                begin
                    mode_next  = q_word.escape;
                    phase_next = q_word.escape ? PH_ZERO : PH_LEAD;
                end
                pos_next = (pos_reg < POS_CAP) ? pos_reg + POS_W'(1) : pos_reg;

                if (phase_next == PH_LEAD)
                begin
                    if (q_word.blank)
                    begin
                        finish = 1'b1;
                    end
                    else if (q_word.minus)
                    begin
                        minus_next = 1'b1;
                        phase_next = PH_GAP;
                        finish     = 1'b1;
                    end
                    else if (q_word.plus)
                    begin
                        phase_next = PH_GAP;
                        finish     = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_ZERO;
                    end
                end
                if (!finish && phase_next == PH_GAP)
                begin
                    if (q_word.blank)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_ZERO;
                    end
                end
                if (!finish && phase_next == PH_ZERO)
                begin
                    phase_next = PH_BASE;
                    if (q_word.zero_char)
                    begin
                        base_next = BASE_OCT;
                        seen_next = 1'b1;
                        stop_next = pos_next;
                        finish    = 1'b1;
                    end
                end
                if (!finish && phase_next == PH_BASE)
                begin
                    phase_next = PH_DIGIT;
                    if (q_word.letter_hit)
                    begin
                        base_next = q_word.letter_base;
                        finish    = 1'b1;
                    end
                end
                if (!finish && phase_next == PH_DIGIT)
                begin
                    finish = 1'b1;
                    if (digit_ok && !(mode_next && (|acc_cand[VALUE_W-1:8])))
                    begin
                        acc_next  = acc_cand;
                        seen_next = 1'b1;
                        stop_next = pos_next;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                if (!finish)
                begin
                    phase_next = PH_DONE;
                end
            end
        end
    end

    // Result register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop && q_word.end_flag)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            mode_reg      <= 1'b0;
            minus_reg     <= 1'b0;
            base_reg      <= BASE_DEC;
            acc_reg       <= '0;
            seen_reg      <= 1'b0;
            pos_reg       <= '0;
            stop_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            mode_reg      <= mode_next;
            minus_reg     <= minus_next;
            base_reg      <= base_next;
            acc_reg       <= acc_next;
            seen_reg      <= seen_next;
            pos_reg       <= pos_next;
            stop_reg      <= stop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, zero when no digit was converted.
    always_ff @(posedge clk)
    begin
        if (pop && q_word.end_flag)
        begin
            ok_reg    <= seen_reg;
            value_reg <= seen_reg ? (minus_reg ? (~acc_reg + VALUE_W'(1)) : acc_reg) : '0;
            count_reg <= seen_reg ? stop_reg : '0;
        end
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.ok             = ok_reg;
    assign result_out.result_value   = value_reg;
    assign result_out.consumed_count = count_reg;
endmodule

@@ src/text_integer_parser_unit.sv @@
// Top level of the streaming text-to-integer parser.
// The block takes one character word per clock while its queue has room
// and turns the string, closed by a terminator word, into a signed 64-bit
// value with an ok flag and the count of characters up to the last converted
// digit. Every word, the terminator included, is handled by one parser step,
// so strings stream back to back at one word per cycle while results are
// taken from the output; the rate is set by the parser step, whose accumulator
// update is a shift or shift-add by the base. A terminator is registered
// in the queue and sets the result register when the parser pops it. A
// two-entry queue sits between the classifier and the parser, so input
// stays ready while a result waits on the output until that queue fills.
module text_integer_parser_unit #(
    parameter int MAX_LENGTH = tip_pkg::MAX_LENGTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tip_in_if.sink    char_in,
    tip_out_if.source result_out
);
    import tip_pkg::*;

    logic     push;
    tip_cls_t push_word;
    logic     q_ready;
    logic     q_valid;
    tip_cls_t q_word;
    logic     pop;

    // Classifier.
    tip_front u_front (
        .char_in   (char_in),
        .q_ready   (q_ready),
        .push      (push),
        .push_word (push_word)
    );

    // Decoupling queue.
    tip_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_word    (q_word)
    );

    // Parser and result register.
    tip_back #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_word     (q_word),
        .pop        (pop),
        .result_out (result_out)
    );
endmodule

@@ src/tip_checker.sv @@
// Port-level checks for the text integer parser, bound to the top level.
module tip_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_end,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_ok,
    input logic [63:0] out_value,
    input logic [12:0] out_count
);
    logic       in_fire;
    logic       out_fire;
    logic [2:0] pending_reg;
    logic [2:0] pending_next;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // Terminators taken whose results have not yet been delivered.
    always_comb
    begin
        pending_next = pending_reg + {2'b00, in_fire && in_end} - {2'b00, out_fire};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 3'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A shown result stays valid and keeps its value and count until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_count))
        else $error("result word changed while stalled");

    // A failed conversion carries zero value and zero count.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ok |-> out_value == 64'd0 && out_count == 13'd0)
        else $error("failed conversion with nonzero payload");

    // No result without a terminator taken before it.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result word without a terminator");

    // Queue plus result register bound the terminators in flight.
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd3)
        else $error("too many terminators in flight");
endmodule

bind text_integer_parser_unit tip_checker u_tip_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (char_in.valid),
    .in_ready  (char_in.ready),
    .in_end    (char_in.end_of_string),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_ok    (result_out.ok),
    .out_value (result_out.result_value),
    .out_count (result_out.consumed_count)
);
